/* rtl/core/page_ref_count_table_defines.svh */
// ----------------------------------------------------------------------------
// page_ref_count_table_defines
// Assertion macros for the page reference count table.
// ----------------------------------------------------------------------------
`ifndef PAGE_REF_COUNT_TABLE_DEFINES_SVH
`define PAGE_REF_COUNT_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PRCT_ASSERT_SAME(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("prct: same-cycle check failed");
`define PRCT_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("prct: next-cycle check failed");
`else
`define PRCT_ASSERT_SAME(label, clk, rst_n, lhs, rhs)
`define PRCT_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif

`endif

/* rtl/core/prct_pkg.sv */
// ----------------------------------------------------------------------------
// prct_pkg
// Types, codes and sizes shared by the page reference count table.
// ----------------------------------------------------------------------------
package prct_pkg;

	localparam int PAGES    = 4096;
	localparam int GEN_BITS = 24;
	localparam int ADDR_W   = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int LIM_W    = 17;

	localparam logic [1:0] OP_VALIDATE = 2'd0;
	localparam logic [1:0] OP_WRITE    = 2'd1;
	localparam logic [1:0] OP_QUERY    = 2'd2;

	localparam logic [3:0] ST_OK       = 4'd0;
	localparam logic [3:0] ST_ZERO     = 4'd1;
	localparam logic [3:0] ST_DEVICE   = 4'd2;
	localparam logic [3:0] ST_RANGE    = 4'd3;
	localparam logic [3:0] ST_GEN      = 4'd4;
	localparam logic [3:0] ST_PRECOND  = 4'd5;
	localparam logic [3:0] ST_FIRST_LT2 = 4'd6;
	localparam logic [3:0] ST_BELOW1   = 4'd7;
	localparam logic [3:0] ST_WRAP     = 4'd8;
	localparam logic [3:0] ST_NEGATIVE = 4'd9;

	localparam logic CFG_OWN_DEVICE = 1'b0;
	localparam logic CFG_PAGE_COUNT = 1'b1;

	typedef struct packed {
		logic [1:0]         operation;
		logic [7:0]         page_device;
		logic [15:0]        page_index;
		logic [23:0]        page_generation;
		logic signed [31:0] count_value;
		logic               drop_request;
		logic [63:0]        log_offset;
	} req_t;

	typedef struct packed {
		logic [3:0]         status;
		logic signed [31:0] result_count;
		logic [23:0]        result_generation;
		logic               newer_flag;
	} rsp_t;

	typedef struct packed {
		logic [31:0]         count;
		logic [GEN_BITS-1:0] generation;
		logic [63:0]         upd_offset;
	} entry_t;

	typedef struct packed {
		logic              capture;
		logic              finish;
		logic              clear;
		logic [ADDR_W-1:0] clr_addr;
	} cmd_t;

endpackage

/* rtl/core/prct_if.sv */
// ----------------------------------------------------------------------------
// prct_req_if / prct_rsp_if
// Valid/ready channels for request and result beats.
// ----------------------------------------------------------------------------
interface prct_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [7:0]         page_device;
	logic [15:0]        page_index;
	logic [23:0]        page_generation;
	logic signed [31:0] count_value;
	logic               drop_request;
	logic [63:0]        log_offset;

	modport source (output valid, operation, page_device, page_index, page_generation,
		count_value, drop_request, log_offset, input ready);
	modport sink (input valid, operation, page_device, page_index, page_generation,
		count_value, drop_request, log_offset, output ready);
endinterface

interface prct_rsp_if;
	logic               valid;
	logic               ready;
	logic [3:0]         status;
	logic signed [31:0] result_count;
	logic [23:0]        result_generation;
	logic               newer_flag;

	modport source (output valid, status, result_count, result_generation, newer_flag,
		input ready);
	modport sink (input valid, status, result_count, result_generation, newer_flag,
		output ready);
endinterface

/* rtl/core/prct_ctrl.sv */
// ----------------------------------------------------------------------------
// prct_ctrl
// Sequencer: table clearing sweep, request capture and result hand-off.
// ----------------------------------------------------------------------------
module prct_ctrl
	import prct_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	output cmd_t cmd
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_LOOK  = 2'd2;

	logic [1:0]        state_q;
	logic [ADDR_W-1:0] clr_q;
	logic              out_valid_q;
	logic              finish;

	assign req_ready = (state_q == S_IDLE);
	assign finish    = (state_q == S_LOOK) && (!out_valid_q || rsp_ready);
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd.capture  = req_valid && req_ready;
		cmd.finish   = finish;
		cmd.clear    = (state_q == S_CLEAR);
		cmd.clr_addr = clr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(PAGES - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid)
						state_q <= S_LOOK;
				end
				S_LOOK: begin
					if (finish)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (finish)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

/* rtl/core/prct_dp.sv */
// ----------------------------------------------------------------------------
// prct_dp
// Page table memory, configuration registers, checks and result register.
// ----------------------------------------------------------------------------
module prct_dp
	import prct_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	input  cmd_t        cmd,
	input  req_t        req_in,
	output rsp_t        rsp_out
);

	entry_t mem [PAGES];

	logic [7:0]  own_device_q;
	logic [12:0] page_count_q;
	req_t        req_q;
	entry_t      rd_q;
	rsp_t        rsp_q;

	logic [LIM_W-1:0]    limit;
	logic                in_rng;
	logic [GEN_BITS-1:0] pgen;
	logic signed [32:0]  old_c;
	logic signed [32:0]  delta;
	logic signed [32:0]  sum;
	logic [63:0]         diff;
	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	entry_t              wr_data;
	rsp_t                res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_device_q <= '0;
			page_count_q <= 13'd4096;
		end else if (cfg_we) begin
			if (cfg_index == CFG_OWN_DEVICE)
				own_device_q <= cfg_data[7:0];
			else
				page_count_q <= cfg_data;
		end
	end

	always_comb begin
		if (LIM_W'(page_count_q) > LIM_W'(PAGES))
			limit = LIM_W'(PAGES);
		else
			limit = LIM_W'(page_count_q);
		in_rng = LIM_W'(req_q.page_index) < limit;
		pgen   = GEN_BITS'(req_q.page_generation);
		old_c  = 33'(signed'(rd_q.count));
		delta  = 33'(req_q.count_value);
		sum    = old_c + delta;
		diff   = req_q.log_offset - rd_q.upd_offset;
	end

	always_comb begin
		res = '0;
		case (req_q.operation)
			OP_VALIDATE: begin
				if (!req_q.drop_request && req_q.count_value == 32'sd0)
					res.status = ST_ZERO;
				else if (req_q.page_device != own_device_q)
					res.status = ST_DEVICE;
				else if (!in_rng)
					res.status = ST_RANGE;
				else if (old_c < 0)
					res.status = ST_NEGATIVE;
				else if (pgen != rd_q.generation)
					res.status = ST_GEN;
				else if (req_q.drop_request) begin
					if (old_c != 33'sd1)
						res.status = ST_PRECOND;
					else
						res.result_generation = 24'(GEN_BITS'(pgen + 1'b1));
				end else if (old_c == 33'sd1)
					res.status = ST_PRECOND;
				else if (delta > 0 && sum > 33'sd2147483647)
					res.status = ST_WRAP;
				else if (delta > 0 && old_c == 0 && sum < 33'sd2)
					res.status = ST_FIRST_LT2;
				else if (delta <= 0 && sum < 33'sd1)
					res.status = ST_BELOW1;
				else begin
					res.result_count      = sum[31:0];
					res.result_generation = 24'(pgen);
				end
			end
			OP_WRITE: begin
				if (!in_rng)
					res.status = ST_RANGE;
			end
			OP_QUERY: begin
				if (!in_rng)
					res.status = ST_RANGE;
				else
					res.newer_flag = diff[63];
			end
			default: res.status = ST_PRECOND;
		endcase
	end

	always_comb begin
		wr_data.count      = req_q.count_value;
		wr_data.generation = pgen;
		wr_data.upd_offset = req_q.log_offset;
		wr_addr            = req_q.page_index[ADDR_W-1:0];
		wr_en              = cmd.finish && req_q.operation == OP_WRITE && in_rng;
		if (cmd.clear) begin
			wr_data = '0;
			wr_addr = cmd.clr_addr;
			wr_en   = 1'b1;
		end
	end

	// indices past the table read an aliased entry (index truncated to ADDR_W bits); the range check discards it
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (cmd.capture)
			rd_q <= mem[req_in.page_index[ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			req_q <= req_in;
		if (cmd.finish)
			rsp_q <= res;
	end

	assign rsp_out = rsp_q;

endmodule

/* rtl/core/page_ref_count_table.sv */
// ----------------------------------------------------------------------------
// page_ref_count_table
// Per-page reference count, generation and last-update offset table with
// validate, write and query operations.
//
//   channel  dir  handshake     beat
//   req      in   valid/ready   operation, page id, count, drop, log offset
//   rsp      out  valid/ready   status, count, generation, newer flag
//   cfg      in   cfg_we        cfg_index, cfg_data
//
// Two steps per request: table read on capture, then check and write-back.
// After reset the table is swept to zero over PAGES (4096) entries; req is
// held off during the sweep, cfg writes are taken.
// The result register frees the request side: a new request is taken while
// the previous result waits; only a second finished result stalls.
// ----------------------------------------------------------------------------
`include "page_ref_count_table_defines.svh"

module page_ref_count_table
	import prct_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	prct_req_if.sink    req,
	prct_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data
);

	cmd_t cmd;
	req_t req_in;
	rsp_t rsp_out;
	logic req_ready;
	logic rsp_valid;

	always_comb begin
		req_in.operation       = req.operation;
		req_in.page_device     = req.page_device;
		req_in.page_index      = req.page_index;
		req_in.page_generation = req.page_generation;
		req_in.count_value     = req.count_value;
		req_in.drop_request    = req.drop_request;
		req_in.log_offset      = req.log_offset;
	end

	assign req.ready             = req_ready;
	assign rsp.valid             = rsp_valid;
	assign rsp.status            = rsp_out.status;
	assign rsp.result_count      = rsp_out.result_count;
	assign rsp.result_generation = rsp_out.result_generation;
	assign rsp.newer_flag        = rsp_out.newer_flag;

	prct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	prct_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.req_in    (req_in),
		.rsp_out   (rsp_out)
	);

	`PRCT_ASSERT_SAME(a_no_req_in_sweep, clk, arst_n, cmd.clear, !req_ready)
	`PRCT_ASSERT_NEXT(a_two_cycle_item, clk, arst_n, cmd.capture, !req_ready)
	`PRCT_ASSERT_NEXT(a_finish_shows, clk, arst_n, cmd.finish, rsp_valid)
	`PRCT_ASSERT_SAME(a_finish_room, clk, arst_n, cmd.finish && rsp_valid, rsp.ready)

endmodule

/* tb/page_ref_count_checker.sv */
// ----------------------------------------------------------------------------
// page_ref_count_checker
// Watches the request, result and register ports of the page reference
// count table. Keeps its own copy of the per-page counts, generations and
// last-update offsets, works out the result of each request beat when it is
// taken, and compares result beats field by field in order.
// ----------------------------------------------------------------------------
module page_ref_count_checker
	import prct_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	prct_req_if         req,
	prct_rsp_if         rsp,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	output int          mismatches,
	output int          outstanding,
	output int          checked
);

	logic [31:0]         page_refs  [PAGES];
	logic [GEN_BITS-1:0] page_gens  [PAGES];
	logic [63:0]         page_slots [PAGES];
	logic [7:0]          own_device;
	logic [12:0]         page_count;
	rsp_t                pending_results [$];

	task automatic flag_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (mismatches < 40)
			$display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	function automatic logic page_in_range(logic [15:0] idx);
		int lim;
		lim = (page_count > PAGES) ? PAGES : int'(page_count);
		return int'(idx) < lim;
	endfunction

	function automatic rsp_t check_delta(req_t r);
		rsp_t o;
		logic [ADDR_W-1:0] a;
		longint stored, delta, total;
		o = '0;
		a = r.page_index[ADDR_W-1:0];
		delta = longint'($signed(r.count_value));
		if (!r.drop_request && delta == 0) begin
			o.status = ST_ZERO;
			return o;
		end
		if (r.page_device != own_device) begin
			o.status = ST_DEVICE;
			return o;
		end
		if (!page_in_range(r.page_index)) begin
			o.status = ST_RANGE;
			return o;
		end
		stored = longint'($signed(page_refs[a]));
		if (stored < 0) begin
			o.status = ST_NEGATIVE;
			return o;
		end
		if (r.page_generation[GEN_BITS-1:0] != page_gens[a]) begin
			o.status = ST_GEN;
			return o;
		end
		if (r.drop_request) begin
			if (stored != 1) begin
				o.status = ST_PRECOND;
				return o;
			end
			o.result_generation = r.page_generation[GEN_BITS-1:0] + 1'b1;
			return o;
		end
		if (stored == 1) begin
			o.status = ST_PRECOND;
			return o;
		end
		total = stored + delta;
		if (delta > 0) begin
			if (total > longint'(32'h7FFF_FFFF)) begin
				o.status = ST_WRAP;
				return o;
			end
			if (stored == 0 && total < 2) begin
				o.status = ST_FIRST_LT2;
				return o;
			end
		end else if (total < 1) begin
			o.status = ST_BELOW1;
			return o;
		end
		o.result_count = total[31:0];
		o.result_generation = r.page_generation[GEN_BITS-1:0];
		return o;
	endfunction

	// write updates the table copy; all others leave it alone
	function automatic rsp_t predict_response(req_t r);
		rsp_t o;
		logic [ADDR_W-1:0] a;
		logic [63:0] gap;
		o = '0;
		a = r.page_index[ADDR_W-1:0];
		case (r.operation)
		OP_VALIDATE: o = check_delta(r);
		OP_WRITE: begin
			if (!page_in_range(r.page_index)) begin
				o.status = ST_RANGE;
			end else begin
				page_refs[a] = r.count_value;
				page_gens[a] = r.page_generation[GEN_BITS-1:0];
				page_slots[a] = r.log_offset;
			end
		end
		OP_QUERY: begin
			if (!page_in_range(r.page_index)) begin
				o.status = ST_RANGE;
			end else begin
				gap = r.log_offset - page_slots[a];
				o.newer_flag = gap[63];
			end
		end
		default: o.status = ST_PRECOND;
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		req_t taken;
		rsp_t want;
		if (!arst_n) begin
			foreach (page_refs[i]) begin
				page_refs[i] = '0;
				page_gens[i] = '0;
				page_slots[i] = '0;
			end
			own_device = 8'd0;
			page_count = 13'd4096;
			pending_results.delete();
			mismatches = 0;
			checked = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_OWN_DEVICE)
					own_device = cfg_data[7:0];
				else
					page_count = cfg_data;
			end
			if (rsp.valid && rsp.ready) begin
				if (pending_results.size() == 0) begin
					flag_mismatch("result beat with nothing expected", 64'(rsp.status), '0);
				end else begin
					want = pending_results.pop_front();
					checked++;
					if (rsp.status !== want.status)
						flag_mismatch("status", 64'(rsp.status), 64'(want.status));
					if (rsp.result_count !== want.result_count)
						flag_mismatch("result_count", 64'(rsp.result_count),
							64'(want.result_count));
					if (rsp.result_generation !== want.result_generation)
						flag_mismatch("result_generation", 64'(rsp.result_generation),
							64'(want.result_generation));
					if (rsp.newer_flag !== want.newer_flag)
						flag_mismatch("newer_flag", 64'(rsp.newer_flag),
							64'(want.newer_flag));
				end
			end
			if (req.valid && req.ready) begin
				taken.operation = req.operation;
				taken.page_device = req.page_device;
				taken.page_index = req.page_index;
				taken.page_generation = req.page_generation;
				taken.count_value = req.count_value;
				taken.drop_request = req.drop_request;
				taken.log_offset = req.log_offset;
				pending_results.push_back(predict_response(taken));
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

/* tb/page_ref_count_table_test.sv */
// ----------------------------------------------------------------------------
// page_ref_count_table_test
// Drives the page reference count table: a directed pass over every status
// and operation, then random phases under several register settings and
// sender/receiver idle patterns. The checker beside the block scores results.
// ----------------------------------------------------------------------------
module page_ref_count_table_test;
	import prct_pkg::*;

	localparam int             RANDOM_BEATS = 1500;
	localparam int             PHASES       = 6;
	localparam int             POOL         = 8;
	localparam logic [1:0]     OP_RESERVED  = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [12:0] cfg_data;
	int          mismatches;
	int          outstanding;
	int          checked;
	int          send_idle_pct;
	int          stall_pct;
	int          beats_sent;
	int          page_limit;
	logic [7:0]  own_dev;
	logic [23:0] pool_gen  [POOL];
	logic [63:0] pool_slot [POOL];

	prct_req_if req();
	prct_rsp_if rsp();

	page_ref_count_table uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	page_ref_count_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.checked     (checked)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic req_t beat(logic [1:0] op, logic [7:0] dev, logic [15:0] idx,
		logic [23:0] gen, logic [31:0] cnt, logic drop, logic [63:0] slot);
		req_t b;
		b.operation = op;
		b.page_device = dev;
		b.page_index = idx;
		b.page_generation = gen;
		b.count_value = cnt;
		b.drop_request = drop;
		b.log_offset = slot;
		return b;
	endfunction

	function automatic logic [31:0] pick_count();
		case ($urandom_range(9))
		0: return 32'd0;
		1, 2: return 32'd1;
		3: return 32'd2;
		4: return 32'($urandom_range(3, 40));
		5: return 32'h7FFF_FFFF - 32'($urandom_range(3));
		6: return -32'($urandom_range(1, 3));
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_delta();
		case ($urandom_range(9))
		0: return 32'd0;
		1, 2, 3: return 32'($urandom_range(1, 4));
		4, 5: return -32'($urandom_range(1, 4));
		6: return 32'h7FFF_FFFF - 32'($urandom_range(2));
		7: return 32'h8000_0000 + 32'($urandom_range(2));
		default: return $urandom;
		endcase
	endfunction

	// pool slots 6 and 7 sit either side of the range limit
	function automatic logic [15:0] pool_index(int k);
		if (k < 6)
			return 16'(k);
		if (k == 6)
			return (page_limit > 0) ? 16'(page_limit - 1) : 16'd0;
		return 16'(page_limit);
	endfunction

	task automatic next_beat(output req_t b);
		int kind, k;
		kind = $urandom_range(99);
		k = $urandom_range(POOL - 1);
		b = beat(OP_VALIDATE, own_dev, pool_index(k), pool_gen[k], pick_delta(), 1'b0,
			pool_slot[k] + 64'($urandom_range(8)) - 64'd4);
		if (kind < 10) begin
			b = beat(2'($urandom_range(3)), 8'($urandom), 16'($urandom), 24'($urandom),
				$urandom, 1'($urandom), {$urandom, $urandom});
		end else if (kind < 35) begin
			b.operation = OP_WRITE;
			b.count_value = pick_count();
			if ($urandom_range(4) == 0)
				b.page_generation = ($urandom_range(1) == 0) ? 24'hFF_FFFF : 24'($urandom);
			b.log_offset = ($urandom_range(3) == 0) ? ~64'($urandom_range(15))
				: {$urandom, $urandom};
			pool_gen[k] = b.page_generation;
			pool_slot[k] = b.log_offset;
		end else if (kind < 50) begin
			b.operation = OP_QUERY;
			if ($urandom_range(3) == 0)
				b.log_offset = {$urandom, $urandom};
		end else begin
			b.drop_request = ($urandom_range(4) == 0);
			if ($urandom_range(12) == 0)
				b.page_generation = b.page_generation + 1'b1;
			if ($urandom_range(19) == 0)
				b.page_device = own_dev ^ 8'(1 << $urandom_range(7));
		end
	endtask

	task automatic send(input req_t b);
		if ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req.valid <= 1'b1;
		req.operation <= b.operation;
		req.page_device <= b.page_device;
		req.page_index <= b.page_index;
		req.page_generation <= b.page_generation;
		req.count_value <= b.count_value;
		req.drop_request <= b.drop_request;
		req.log_offset <= b.log_offset;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		beats_sent++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic index, input logic [12:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		req_t b;
		logic [12:0] pc;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_OWN_DEVICE;
		cfg_data = '0;
		req.valid = 1'b0;
		req.operation = OP_VALIDATE;
		req.page_device = '0;
		req.page_index = '0;
		req.page_generation = '0;
		req.count_value = '0;
		req.drop_request = 1'b0;
		req.log_offset = '0;
		rsp.ready = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		beats_sent = 0;
		own_dev = 8'd0;
		page_limit = PAGES;
		foreach (pool_gen[i]) begin
			pool_gen[i] = '0;
			pool_slot[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed pass on reset register values
		send(beat(OP_VALIDATE, 8'h00, 16'd5, 24'd0, 32'd0, 1'b0, '0));
		send(beat(OP_VALIDATE, 8'hFF, 16'd5, 24'd0, 32'd3, 1'b0, '0));
		send(beat(OP_VALIDATE, 8'h00, 16'hFFFF, 24'd0, 32'd3, 1'b0, '0));
		send(beat(OP_VALIDATE, 8'h00, 16'd5, 24'd0, 32'd1, 1'b0, '0));
		send(beat(OP_VALIDATE, 8'h00, 16'd5, 24'd0, 32'd2, 1'b0, '0));
		send(beat(OP_VALIDATE, 8'h00, 16'd5, 24'd0, 32'd0, 1'b1, '0));
		send(beat(OP_WRITE, 8'hA5, 16'd5, 24'hFF_FFFF, 32'd1, 1'b0,
			64'hFFFF_FFFF_FFFF_FFF0));
		send(beat(OP_VALIDATE, 8'h00, 16'd5, 24'd0, 32'd1, 1'b0, '0));
		send(beat(OP_VALIDATE, 8'h00, 16'd5, 24'hFF_FFFF, 32'h7FFF_FFFF, 1'b1, '0));
		send(beat(OP_VALIDATE, 8'h00, 16'd5, 24'hFF_FFFF, 32'd3, 1'b0, '0));
		send(beat(OP_QUERY, 8'h00, 16'd5, 24'd0, 32'd0, 1'b0, 64'h10));
		send(beat(OP_QUERY, 8'h00, 16'd5, 24'd0, 32'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFE0));
		send(beat(OP_WRITE, 8'h00, 16'd6, 24'd7, 32'h7FFF_FFFF, 1'b0, '0));
		send(beat(OP_VALIDATE, 8'h00, 16'd6, 24'd7, 32'd1, 1'b0, '0));
		send(beat(OP_VALIDATE, 8'h00, 16'd6, 24'd7, 32'h8000_0000, 1'b0, '0));
		send(beat(OP_VALIDATE, 8'h00, 16'd6, 24'd7, 32'h8000_0002, 1'b0, '0));
		send(beat(OP_VALIDATE, 8'h00, 16'd6, 24'd7, 32'h8000_0001, 1'b0, '0));
		send(beat(OP_WRITE, 8'h00, 16'd6, 24'd7, 32'hFFFF_FFFF, 1'b0, '0));
		send(beat(OP_VALIDATE, 8'h00, 16'd6, 24'd7, 32'd1, 1'b0, '0));
		send(beat(OP_VALIDATE, 8'h00, 16'd6, 24'd0, 32'd0, 1'b1, '0));
		send(beat(OP_RESERVED, 8'hFF, 16'hFFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 1'b1, '1));
		send(beat(OP_WRITE, 8'h00, 16'd4095, 24'd0, 32'd2, 1'b0, '1));
		send(beat(OP_WRITE, 8'h00, 16'd4096, 24'd0, 32'd2, 1'b0, '1));
		send(beat(OP_QUERY, 8'h00, 16'hFFFF, 24'd0, 32'd0, 1'b0, '0));
		send(beat(OP_VALIDATE, 8'h00, 16'd4095, 24'd0, 32'hFFFF_FFFF, 1'b0, '0));

		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
			0: begin
				own_dev = 8'h00;
				pc = 13'd4096;
			end
			1: begin
				own_dev = 8'hFF;
				pc = 13'h1FFF;
			end
			2: begin
				own_dev = 8'h5A;
				pc = 13'd0;
			end
			3: begin
				own_dev = 8'($urandom);
				pc = 13'd1;
			end
			4: begin
				own_dev = 8'($urandom);
				pc = 13'($urandom_range(2, 40));
			end
			default: begin
				own_dev = 8'hFF;
				pc = 13'd4095;
			end
			endcase
			write_reg(CFG_OWN_DEVICE, {5'($urandom), own_dev});
			write_reg(CFG_PAGE_COUNT, pc);
			page_limit = (pc > PAGES) ? PAGES : int'(pc);
			case (p % 4)
			0: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				send_idle_pct = 49;
				stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 49;
			end
			default: begin
				send_idle_pct = 27;
				stall_pct = 27;
			end
			endcase
			for (int i = 0; i < RANDOM_BEATS / PHASES; i++) begin
				if (i == RANDOM_BEATS / PHASES / 2)
					drain();
				next_beat(b);
				send(b);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		$display("Sent %0d request beats (25 directed) under %0d register settings;",
			beats_sent, PHASES + 1);
		$display("checked %0d result beats across idle, sender, receiver and mixed stalls.",
			checked);
		if (outstanding != 0)
			$display("%0d expected result beats never arrived", outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/prct_pkg.sv
rtl/core/prct_if.sv
rtl/core/prct_ctrl.sv
rtl/core/prct_dp.sv
rtl/core/page_ref_count_table.sv
tb/page_ref_count_checker.sv
tb/page_ref_count_table_test.sv
